// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and sequencer state type for the text console writer.
package tcw_pkg;

  // Default screen geometry.
  localparam int COLS_DEFAULT = 80;
  localparam int ROWS_DEFAULT = 25;

  // Fixed field widths.
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Character and attribute constants.
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd15;

  // Item operation codes.
  typedef enum logic [1:0] {
    MODE_PUT_CURSOR = 2'd0,
    MODE_PUT_POS    = 2'd1,
    MODE_SET_CURSOR = 2'd2,
    MODE_READ       = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_EXEC,
    ST_READ,
    ST_SCRL_RD,
    ST_SCRL_WR,
    ST_SCRL_CLR,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tcw_addr.sv =====
// Shared address unit: turns a row and column into a linear cell address and checks that they lie on screen.
module tcw_addr
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic                                 clk,
  input  logic [ROW_W-1:0]                     row,
  input  logic [COL_W-1:0]                     col,
  output logic [$clog2(COLS*ROWS)-1:0]         addr,
  output logic                                 on_screen
);

  localparam int AW = $clog2(COLS * ROWS);
  localparam int PW = COL_W + ROW_W + 1;

  logic [PW-1:0] prod;
  logic          in_range;

  // Row times line length plus column, and the bounds check.
  always_comb begin
    prod     = PW'(row) * PW'(COLS) + PW'(col);
    in_range = ({1'b0, col} < (COL_W + 1)'(COLS)) && ({1'b0, row} < (ROW_W + 1)'(ROWS));
  end

  // The result is registered before the sequencer uses it.
  always_ff @(posedge clk) begin
    addr      <= prod[AW-1:0];
    on_screen <= in_range;
  end

endmodule

// ===== hw/rtl/text_console_writer.sv =====
// Top level of the text console writer: sequencer, cursor and screen store.
//
// The console holds ROWS x COLS cells of one character and one attribute byte each, and a
// cursor. After reset the screen store is cleared one cell a cycle, during which in_ready
// stays low; configuration writes are taken throughout. An item then passes through
// address, execute and result steps; an on-screen cell read adds a read step because of
// the store's registered read port. An item that makes the screen scroll also walks the
// store: a read and a write for each of the (ROWS-1)*COLS cells moved up, then a write for
// each of the COLS cells of the cleared last row. One item is in progress at a time; the
// next is taken once the result register has been loaded, even if that result has not yet
// been transferred.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = COLS_DEFAULT,
  parameter int ROWS = ROWS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration register.
  input  logic              cfg_we,
  input  logic [ATTR_W-1:0] cfg_data,
  // Input channel.
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [CHAR_W-1:0] char_code,
  input  logic [ATTR_W-1:0] attribute,
  input  logic [COL_W-1:0]  column,
  input  logic [ROW_W-1:0]  line,
  input  logic              at_cursor,
  // Output channel.
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] read_char,
  output logic [ATTR_W-1:0] read_attribute,
  output logic [COL_W-1:0]  cursor_column,
  output logic [ROW_W-1:0]  cursor_row,
  output logic              scrolled,
  output logic              bad_position
);

  localparam int CELLS = COLS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0]    LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0]    LAST_COPY = AW'(CELLS - COLS - 1);
  localparam logic [AW-1:0]    LINE_STEP = AW'(COLS);
  localparam logic [COL_W-1:0] LAST_COL  = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);

  state_t state, state_next;

  // Configuration and cursor.
  logic [ATTR_W-1:0] def_attr;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;

  // Item held while it is worked on.
  mode_t             op_mode;
  logic [CHAR_W-1:0] op_char;
  logic [ATTR_W-1:0] op_attr;
  logic [COL_W-1:0]  op_col;
  logic [ROW_W-1:0]  op_row;
  logic              op_atc;

  // Per-item results.
  logic              res_scr;
  logic              res_bad;
  logic [CHAR_W-1:0] res_char;
  logic [ATTR_W-1:0] res_attr;

  // Cell pointer for clearing and scrolling.
  logic [AW-1:0] ptr;

  // Address unit and store connections.
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [AW-1:0]     addr_q;
  logic              onscr_q;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Decoded conditions of the current item.
  logic is_newline;
  logic use_cursor;
  logic line_end;
  logic exec_scroll;
  logic out_load;

  assign is_newline  = (op_char == NEWLINE_CODE);
  assign use_cursor  = (op_mode == MODE_PUT_CURSOR) || ((op_mode == MODE_PUT_POS) && op_atc);
  assign line_end    = is_newline || (cur_col == LAST_COL);
  assign exec_scroll = (op_mode == MODE_PUT_CURSOR) && line_end && (cur_row == LAST_ROW);
  assign out_load    = (state == ST_DONE) && (!out_valid || out_ready);
  assign in_ready    = (state == ST_IDLE);

  // The address unit sees either the cursor or the item's position.
  assign sel_row = use_cursor ? cur_row : op_row;
  assign sel_col = use_cursor ? cur_col : op_col;

  tcw_addr #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) u_addr (
    .clk      (clk),
    .row      (sel_row),
    .col      (sel_col),
    .addr     (addr_q),
    .on_screen(onscr_q)
  );

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_ADDR;
        end
      end
      ST_ADDR: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if ((op_mode == MODE_READ) && onscr_q) begin
          state_next = ST_READ;
        end else if (exec_scroll) begin
          state_next = ST_SCRL_RD;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ: begin
        state_next = ST_DONE;
      end
      ST_SCRL_RD: begin
        state_next = ST_SCRL_WR;
      end
      ST_SCRL_WR: begin
        state_next = (ptr == LAST_COPY) ? ST_SCRL_CLR : ST_SCRL_RD;
      end
      ST_SCRL_CLR: begin
        if (ptr == LAST_CELL) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Store accesses for each state.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr;
    ram_wdata = '0;
    ram_raddr = addr_q;
    case (state)
      ST_CLEAR, ST_SCRL_CLR: begin
        ram_we = 1'b1;
      end
      ST_EXEC: begin
        ram_waddr = addr_q;
        ram_wdata = {op_attr, op_char};
        case (op_mode)
          MODE_PUT_CURSOR: ram_we = !is_newline;
          MODE_PUT_POS:    ram_we = !is_newline && (op_atc || onscr_q);
          default:         ram_we = 1'b0;
        endcase
      end
      ST_SCRL_RD: begin
        ram_raddr = ptr + LINE_STEP;
      end
      ST_SCRL_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Control state, cursor and item registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      ptr       <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      out_valid <= 1'b0;
      def_attr  <= ATTR_RESET;
    end else begin
      state <= state_next;

      if (cfg_we) begin
        def_attr <= cfg_data;
      end

      // The pointer sweeps the store and returns to zero at the end.
      if (state inside {ST_CLEAR, ST_SCRL_WR, ST_SCRL_CLR}) begin
        ptr <= (ptr == LAST_CELL) ? '0 : ptr + 1'b1;
      end

      // Cursor updates.
      if (state == ST_EXEC) begin
        case (op_mode)
          MODE_PUT_CURSOR: begin
            if (line_end) begin
              cur_col <= '0;
              if (cur_row != LAST_ROW) begin
                cur_row <= cur_row + 1'b1;
              end
            end else begin
              cur_col <= cur_col + 1'b1;
            end
          end
          MODE_SET_CURSOR: begin
            if (onscr_q) begin
              cur_col <= op_col;
              cur_row <= op_row;
            end
          end
          default: begin
          end
        endcase
      end

      // Result handshake.
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_mode  <= mode_t'(mode);
      op_char  <= char_code;
      op_attr  <= (attribute == '0) ? def_attr : attribute;
      op_col   <= column;
      op_row   <= line;
      op_atc   <= at_cursor;
      res_scr  <= 1'b0;
      res_bad  <= 1'b0;
      res_char <= '0;
      res_attr <= '0;
    end

    if (state == ST_EXEC) begin
      res_scr <= exec_scroll;
      case (op_mode)
        MODE_PUT_POS:    res_bad <= !op_atc && !onscr_q;
        MODE_SET_CURSOR: res_bad <= !onscr_q;
        MODE_READ:       res_bad <= !onscr_q;
        default:         res_bad <= 1'b0;
      endcase
    end

    if (state == ST_READ) begin
      res_char <= ram_rdata[CHAR_W-1:0];
      res_attr <= ram_rdata[CELL_W-1:CHAR_W];
    end

    if (out_load) begin
      read_char      <= res_char;
      read_attribute <= res_attr;
      cursor_column  <= cur_col;
      cursor_row     <= cur_row;
      scrolled       <= res_scr;
      bad_position   <= res_bad;
    end
  end

  // The cursor never leaves the screen.
  a_cursor_on_screen: assert property (@(posedge clk) disable iff (rst)
    (cur_col <= LAST_COL) && (cur_row <= LAST_ROW))
    else $error("cursor left the screen");

  // A scroll leaves the cursor at the start of the last row.
  a_scroll_cursor: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> ((cursor_row == LAST_ROW) && (cursor_column == '0)))
    else $error("cursor not at start of last row after scroll");

  // An off-screen item never returns cell data.
  a_bad_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_position) |-> ((read_char == '0) && (read_attribute == '0)))
    else $error("off-screen item returned cell data");

  // A new result is only loaded once the previous one has been transferred.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cursor_column) && $stable(read_char)))
    else $error("pending result was overwritten");

endmodule
